// ===== rtl/fttoi_pkg.sv =====
// Package for the text-to-integer parser: shared types, register indexes,
// reset values and character constants. No dependencies.
package fttoi_pkg;

    // Field widths
    localparam int unsigned CH_W    = 8;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_CHAR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CHAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLUS_CHAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_CASE = 3'd5;

    // Fill modes
    localparam logic [MODE_W-1:0] FILL_BEFORE_SIGN = 2'd0;
    localparam logic [MODE_W-1:0] FILL_AFTER_SIGN  = 2'd1;

    // Letter case modes
    localparam logic [MODE_W-1:0] CASE_UPPER_ONLY = 2'd1;
    localparam logic [MODE_W-1:0] CASE_LOWER_ONLY = 2'd2;

    // Register reset values
    localparam logic [BASE_W-1:0] RST_NUMBER_BASE = 6'd10;
    localparam logic [CH_W-1:0]   RST_FILL_CHAR   = 8'd0;
    localparam logic [CH_W-1:0]   RST_MINUS_CHAR  = 8'd45;
    localparam logic [CH_W-1:0]   RST_PLUS_CHAR   = 8'd0;
    localparam logic [MODE_W-1:0] RST_FILL_MODE   = 2'd0;
    localparam logic [MODE_W-1:0] RST_LETTER_CASE = 2'd0;

    // Radix limits
    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    // Character codes and letter offsets
    localparam logic [CH_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [CH_W-1:0] UPPER_OFS   = 8'd55;
    localparam logic [CH_W-1:0] LOWER_OFS   = 8'd87;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Parser phase
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SIGNED = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Classification of one character under the current configuration
    typedef struct packed {
        logic              is_fill;
        logic              is_minus;
        logic              is_plus;
        logic              is_digit;
        logic [BASE_W-1:0] digit;
    } t_char_class;

    // One result beat
    typedef struct packed {
        logic               taken;
        logic               finished;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] used_count;
    } t_result;

endpackage

// ===== rtl/formatted_text_to_integer.sv =====
// Top level of the text-to-integer parser: configuration registers, input
// register, output register and stream handshake.
// Depends on fttoi_pkg, fttoi_decode and fttoi_parse.
//
// Usage: characters enter on the s_axis channel, one per beat (tdata = ch,
// tuser = begin_req, set on the first character of a new string). Every input
// beat yields exactly one result beat on m_axis carrying the signed value
// parsed so far, the saturating count of consumed characters and the
// taken/finished flags. The user must write registers on the i_cfg port only
// while the block is idle; the block itself does not enforce this.
// Each character passes through the input register, then the result register.
// Throughput: one character per cycle while the receiver does not stall, set by the
// accumulator loop (one 64x6 multiply and add per cycle).
// Reset clears the parser state, empties both stages and loads the register
// defaults (radix 10, minus sign '-'). When the receiver stalls, the result
// register holds, the input register fills, and s_axis_tready drops until
// m_axis_tready returns; no beat is lost.
module formatted_text_to_integer
    import fttoi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input characters
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] ch
    input  logic [0:0]             s_axis_tuser,   // [0] begin_req
    // Results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [79:0]            m_axis_tdata,   // [63:0] value, [79:64] used_count
    output logic [1:0]             m_axis_tuser    // [0] taken, [1] finished
);

    // Configuration registers
    logic [BASE_W-1:0] r_number_base;
    logic [CH_W-1:0]   r_fill_char;
    logic [CH_W-1:0]   r_minus_char;
    logic [CH_W-1:0]   r_plus_char;
    logic [MODE_W-1:0] r_fill_mode;
    logic [MODE_W-1:0] r_letter_case;

    // Input stage
    logic              r_in_valid;
    logic              r_in_begin;
    t_char_class       r_in_class;

    // Output stage
    logic              r_out_valid;
    t_result           r_out;

    logic              w_advance;
    logic [BASE_W-1:0] w_eff_base;
    t_char_class       w_class;
    t_result           w_result;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= RST_NUMBER_BASE;
            r_fill_char   <= RST_FILL_CHAR;
            r_minus_char  <= RST_MINUS_CHAR;
            r_plus_char   <= RST_PLUS_CHAR;
            r_fill_mode   <= RST_FILL_MODE;
            r_letter_case <= RST_LETTER_CASE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NUMBER_BASE: r_number_base <= i_cfg_wdata[BASE_W-1:0];
                CFG_FILL_CHAR:   r_fill_char   <= i_cfg_wdata[CH_W-1:0];
                CFG_MINUS_CHAR:  r_minus_char  <= i_cfg_wdata[CH_W-1:0];
                CFG_PLUS_CHAR:   r_plus_char   <= i_cfg_wdata[CH_W-1:0];
                CFG_FILL_MODE:   r_fill_mode   <= i_cfg_wdata[MODE_W-1:0];
                CFG_LETTER_CASE: r_letter_case <= i_cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the incoming character ahead of the input register
    fttoi_decode u_decode (
        .i_ch          (s_axis_tdata),
        .i_number_base (r_number_base),
        .i_fill_char   (r_fill_char),
        .i_minus_char  (r_minus_char),
        .i_plus_char   (r_plus_char),
        .i_letter_case (r_letter_case),
        .o_eff_base    (w_eff_base),
        .o_class       (w_class)
    );

    // Handshake: the input stage moves on when the result register is free
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_begin <= s_axis_tuser[0];
            r_in_class <= w_class;
        end
    end

    // Parser state and next result
    fttoi_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_begin     (r_in_begin),
        .i_class     (r_in_class),
        .i_eff_base  (w_eff_base),
        .i_fill_mode (r_fill_mode),
        .o_result    (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.used_count, r_out.value};
    assign m_axis_tuser  = {r_out.finished, r_out.taken};

    // A character that stops the parse is never counted as taken
    a_taken_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.taken && r_out.finished))
        else $error("result both taken and finished");

    // A waiting input beat holds its class while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_class)))
        else $error("input stage lost a stalled beat");

    // A stalled result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("result register changed under stall");

    // Both stages empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule

// ===== rtl/fttoi_decode.sv =====
// Character classifier: fill, sign and digit detection plus radix clamp.
// Depends on fttoi_pkg.
module fttoi_decode
    import fttoi_pkg::*;
(
    input  logic [CH_W-1:0]   i_ch,
    input  logic [BASE_W-1:0] i_number_base,
    input  logic [CH_W-1:0]   i_fill_char,
    input  logic [CH_W-1:0]   i_minus_char,
    input  logic [CH_W-1:0]   i_plus_char,
    input  logic [MODE_W-1:0] i_letter_case,
    output logic [BASE_W-1:0] o_eff_base,
    output t_char_class       o_class
);

    logic [BASE_W-1:0] w_base;
    logic [CH_W-1:0]   w_raw;
    logic              w_num;
    logic              w_up_ok;
    logic              w_lo_ok;

    // Radix clamped to 2..36
    always_comb begin
        priority if (i_number_base < BASE_MIN) begin
            w_base = BASE_MIN;
        end else if (i_number_base > BASE_MAX) begin
            w_base = BASE_MAX;
        end else begin
            w_base = i_number_base;
        end
    end

    // Raw digit value from decimal digits and letters
    always_comb begin
        w_up_ok = (i_letter_case != CASE_LOWER_ONLY);
        w_lo_ok = (i_letter_case != CASE_UPPER_ONLY);
        priority if (i_ch >= CHAR_ZERO && i_ch <= CHAR_NINE) begin
            w_raw = i_ch - CHAR_ZERO;
            w_num = 1'b1;
        end else if (w_up_ok && i_ch >= CHAR_UP_A && i_ch <= CHAR_UP_Z) begin
            w_raw = i_ch - UPPER_OFS;
            w_num = 1'b1;
        end else if (w_lo_ok && i_ch >= CHAR_LO_A && i_ch <= CHAR_LO_Z) begin
            w_raw = i_ch - LOWER_OFS;
            w_num = 1'b1;
        end else begin
            w_raw = '0;
            w_num = 1'b0;
        end
    end

    // Digit must lie below the radix; raw values stay under 36
    always_comb begin
        o_class.digit    = w_raw[BASE_W-1:0];
        o_class.is_digit = w_num && (w_raw[BASE_W-1:0] < w_base);
        o_class.is_fill  = (i_fill_char  != CHAR_NUL) && (i_ch == i_fill_char);
        o_class.is_minus = (i_minus_char != CHAR_NUL) && (i_ch == i_minus_char);
        o_class.is_plus  = (i_plus_char  != CHAR_NUL) && (i_ch == i_plus_char);
    end

    assign o_eff_base = w_base;

endmodule

// ===== rtl/fttoi_parse.sv =====
// Parser state (phase, signed accumulator, sign, count) and next-result logic.
// Depends on fttoi_pkg.
module fttoi_parse
    import fttoi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_begin,
    input  t_char_class       i_class,
    input  logic [BASE_W-1:0] i_eff_base,
    input  logic [MODE_W-1:0] i_fill_mode,
    output t_result           o_result
);

    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_neg, n_neg;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               w_take;
    logic [VALUE_W-1:0] w_prod;

    // Accumulator holds the signed value directly: acc*base +/- digit
    assign w_prod = (i_begin ? '0 : r_acc) * {{(VALUE_W-BASE_W){1'b0}}, i_eff_base};

    // Phase walk for one character
    always_comb begin
        n_phase = i_begin ? PH_LEAD : r_phase;
        n_acc   = i_begin ? '0      : r_acc;
        n_neg   = i_begin ? 1'b0    : r_neg;
        n_count = i_begin ? '0      : r_count;
        w_take  = 1'b0;

        if (n_phase == PH_LEAD) begin
            priority if (i_class.is_fill && i_fill_mode == FILL_BEFORE_SIGN) begin
                w_take = 1'b1;
            end else if (i_class.is_minus) begin
                n_neg   = 1'b1;
                n_phase = PH_SIGNED;
                w_take  = 1'b1;
            end else if (i_class.is_plus) begin
                n_phase = PH_SIGNED;
                w_take  = 1'b1;
            end else begin
                n_phase = PH_SIGNED;
            end
        end
        if (!w_take && n_phase == PH_SIGNED) begin
            if (i_class.is_fill && i_fill_mode == FILL_AFTER_SIGN) begin
                w_take = 1'b1;
            end else begin
                n_phase = PH_DIGITS;
            end
        end
        if (!w_take && n_phase == PH_DIGITS) begin
            if (i_class.is_digit) begin
                if (n_neg) begin
                    n_acc = w_prod - {{(VALUE_W-BASE_W){1'b0}}, i_class.digit};
                end else begin
                    n_acc = w_prod + {{(VALUE_W-BASE_W){1'b0}}, i_class.digit};
                end
                w_take = 1'b1;
            end else begin
                n_phase = PH_DONE;
            end
        end

        // Saturating count of consumed characters
        if (w_take && n_count != COUNT_MAX) begin
            n_count = n_count + 1'b1;
        end
    end

    // Result for this beat
    always_comb begin
        o_result.taken      = w_take;
        o_result.finished   = (n_phase == PH_DONE);
        o_result.value      = n_acc;
        o_result.used_count = n_count;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_count <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_count <= n_count;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for formatted_text_to_integer: streams characters
// through the parser and checks every result beat against an in-bench model.
// Depends on fttoi_pkg and the RTL top level only.
module tb_top;
    import fttoi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes not named in the package
    localparam logic [MODE_W-1:0] FILL_RIGHT    = 2'd2;
    localparam logic [MODE_W-1:0] FILL_MODE_ALT = 2'd3;   // behaves as right fill
    localparam logic [MODE_W-1:0] CASE_BOTH     = 2'd0;
    localparam logic [MODE_W-1:0] CASE_ALT      = 2'd3;   // behaves as both cases
    localparam logic [6:0]        NOT_A_DIGIT   = 7'd64;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int LONG_STALL      = 400;
    localparam int HALF_PHASE      = 108;
    localparam int RANDOM_PHASES   = 8;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            begin_req;
    } t_char_beat;

    // DUT signals
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] ch
    logic [0:0]            s_axis_tuser  = '0;   // [0] begin_req
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;         // [63:0] value, [79:64] used_count
    logic [1:0]            m_axis_tuser;         // [0] taken, [1] finished

    // Model copy of the registers
    logic [BASE_W-1:0] cfg_base;
    logic [CH_W-1:0]   cfg_fill;
    logic [CH_W-1:0]   cfg_minus;
    logic [CH_W-1:0]   cfg_plus;
    logic [MODE_W-1:0] cfg_fill_mode;
    logic [MODE_W-1:0] cfg_case;

    // Model copy of the parser state
    t_phase             prs_phase;
    logic [VALUE_W-1:0] prs_mag;
    logic               prs_neg;
    logic [COUNT_W-1:0] prs_count;

    t_char_beat text_chars[$];
    t_result    predicted_parses[$];
    t_char_beat next_beat;
    t_result    want_res;
    t_result    got_res;
    logic       begin_pending;

    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;
    int errors             = 0;
    int chars_sent         = 0;
    int results_checked    = 0;
    int configs_applied    = 0;
    int quiet_cycles       = 0;
    int stall_left         = 0;
    bit stall_req          = 1'b0;
    bit stall_ack          = 1'b0;

    formatted_text_to_integer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Radix clamped to 2..36
    function automatic logic [BASE_W-1:0] eff_radix();
        if (cfg_base < BASE_MIN) return BASE_MIN;
        else if (cfg_base > BASE_MAX) return BASE_MAX;
        return cfg_base;
    endfunction

    function automatic logic [6:0] digit_value(input logic [CH_W-1:0] c);
        logic [6:0] d;
        d = NOT_A_DIGIT;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 7'(c - CHAR_ZERO);
        end else if (cfg_case != CASE_LOWER_ONLY && c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = 7'(c - UPPER_OFS);
        end else if (cfg_case != CASE_UPPER_ONLY && c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = 7'(c - LOWER_OFS);
        end
        if (d >= {1'b0, eff_radix()}) d = NOT_A_DIGIT;
        return d;
    endfunction

    // Advance the parser model by one character and return the result beat
    function automatic t_result parse_char(input logic [CH_W-1:0] c, input logic start);
        t_result    r;
        logic       take;
        logic [6:0] d;
        take = 1'b0;
        if (start) begin
            prs_phase = PH_LEAD;
            prs_mag   = '0;
            prs_neg   = 1'b0;
            prs_count = '0;
        end
        // fill before sign has priority over the sign characters
        if (prs_phase == PH_LEAD) begin
            if (cfg_fill != CHAR_NUL && cfg_fill_mode == FILL_BEFORE_SIGN && c == cfg_fill) begin
                take = 1'b1;
            end else if (cfg_minus != CHAR_NUL && c == cfg_minus) begin
                prs_neg   = 1'b1;
                prs_phase = PH_SIGNED;
                take      = 1'b1;
            end else if (cfg_plus != CHAR_NUL && c == cfg_plus) begin
                prs_phase = PH_SIGNED;
                take      = 1'b1;
            end else begin
                prs_phase = PH_SIGNED;
            end
        end
        if (!take && prs_phase == PH_SIGNED) begin
            if (cfg_fill != CHAR_NUL && cfg_fill_mode == FILL_AFTER_SIGN && c == cfg_fill)
                take = 1'b1;
            else
                prs_phase = PH_DIGITS;
        end
        if (!take && prs_phase == PH_DIGITS) begin
            d = digit_value(c);
            if (d != NOT_A_DIGIT) begin
                prs_mag = prs_mag * VALUE_W'(eff_radix()) + VALUE_W'(d);
                take    = 1'b1;
            end else begin
                prs_phase = PH_DONE;
            end
        end
        if (take && prs_count != COUNT_MAX) prs_count = prs_count + 1'b1;
        r.taken      = take;
        r.finished   = (prs_phase == PH_DONE);
        r.value      = prs_neg ? (VALUE_W'(0) - prs_mag) : prs_mag;
        r.used_count = prs_count;
        return r;
    endfunction

    // Character that encodes digit d under the current letter case
    function automatic logic [CH_W-1:0] digit_char(input int unsigned d);
        logic use_upper;
        if (d < 10) return CHAR_ZERO + CH_W'(d);
        if (cfg_case == CASE_UPPER_ONLY) use_upper = 1'b1;
        else if (cfg_case == CASE_LOWER_ONLY) use_upper = 1'b0;
        else use_upper = 1'($urandom_range(1, 0));
        return use_upper ? UPPER_OFS + CH_W'(d) : LOWER_OFS + CH_W'(d);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic queue_char(input logic [CH_W-1:0] c);
        t_char_beat beat;
        beat.ch        = c;
        beat.begin_req = begin_pending;
        begin_pending  = 1'b0;
        text_chars.push_back(beat);
    endtask

    task automatic queue_text(input string s);
        begin_pending = 1'b1;
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endtask

    // Well-formed string with random content, sometimes without a begin mark
    task automatic queue_string();
        int unsigned sign_pick;
        int unsigned ndig;
        begin_pending = ($urandom_range(19, 0) != 0);
        if (cfg_fill != CHAR_NUL && cfg_fill_mode == FILL_BEFORE_SIGN)
            repeat ($urandom_range(3, 0)) queue_char(cfg_fill);
        sign_pick = $urandom_range(2, 0);
        if (sign_pick == 1 && cfg_minus != CHAR_NUL) queue_char(cfg_minus);
        else if (sign_pick == 2 && cfg_plus != CHAR_NUL) queue_char(cfg_plus);
        if (cfg_fill != CHAR_NUL && cfg_fill_mode == FILL_AFTER_SIGN)
            repeat ($urandom_range(3, 0)) queue_char(cfg_fill);
        // long runs push the magnitude through wraparound
        ndig = ($urandom_range(7, 0) == 0) ? $urandom_range(70, 20) : $urandom_range(12, 1);
        repeat (ndig) queue_char(digit_char($urandom_range(eff_radix() - 1, 0)));
        // terminator and characters past the end
        repeat ($urandom_range(2, 0)) queue_char(CH_W'($urandom_range(255, 0)));
    endtask

    // Sampled away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (text_chars.size() != 0 || predicted_parses.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_NUMBER_BASE: cfg_base      = data[BASE_W-1:0];
            CFG_FILL_CHAR:   cfg_fill      = data;
            CFG_MINUS_CHAR:  cfg_minus     = data;
            CFG_PLUS_CHAR:   cfg_plus      = data;
            CFG_FILL_MODE:   cfg_fill_mode = data[MODE_W-1:0];
            CFG_LETTER_CASE: cfg_case      = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Program all registers once the parser has gone quiet
    task automatic set_config(input logic [7:0] base, input logic [7:0] fill,
                              input logic [7:0] minus, input logic [7:0] plus,
                              input logic [MODE_W-1:0] fmode,
                              input logic [MODE_W-1:0] lcase);
        wait_drained();
        write_reg(CFG_NUMBER_BASE, base);
        write_reg(CFG_FILL_CHAR, fill);
        write_reg(CFG_MINUS_CHAR, minus);
        write_reg(CFG_PLUS_CHAR, plus);
        write_reg(CFG_FILL_MODE, CFG_DATA_W'(fmode));
        write_reg(CFG_LETTER_CASE, CFG_DATA_W'(lcase));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        configs_applied++;
    endtask

    // Input driver: presents queued characters, predicts on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_parses.push_back(parse_char(s_axis_tdata, s_axis_tuser[0]));
                chars_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (text_chars.size() != 0 && $urandom_range(99, 0) >= sender_gap_pct) begin
                    next_beat = text_chars.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.ch;
                    s_axis_tuser  <= next_beat.begin_req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed by toggling stall_req
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_req != stall_ack) begin
            stall_left <= LONG_STALL;
            stall_ack  <= stall_req;
        end
    end

    // Result monitor: compares each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res.value      = m_axis_tdata[63:0];
                got_res.used_count = m_axis_tdata[79:64];
                got_res.taken      = m_axis_tuser[0];
                got_res.finished   = m_axis_tuser[1];
                if (predicted_parses.size() == 0) begin
                    flag_error($sformatf("result beat with nothing predicted: value %0h count %0d",
                                         got_res.value, got_res.used_count));
                end else begin
                    want_res = predicted_parses.pop_front();
                    if (got_res.taken !== want_res.taken)
                        flag_error($sformatf("beat %0d taken: want %0b got %0b",
                                             results_checked, want_res.taken, got_res.taken));
                    if (got_res.finished !== want_res.finished)
                        flag_error($sformatf("beat %0d finished: want %0b got %0b",
                                             results_checked, want_res.finished,
                                             got_res.finished));
                    if (got_res.value !== want_res.value)
                        flag_error($sformatf("beat %0d value: want %0h got %0h",
                                             results_checked, want_res.value, got_res.value));
                    if (got_res.used_count !== want_res.used_count)
                        flag_error($sformatf("beat %0d used_count: want %0d got %0d",
                                             results_checked, want_res.used_count,
                                             got_res.used_count));
                end
                results_checked++;
            end
            m_axis_tready <= (stall_left == 0) && ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // Watchdog on cycles without any beat or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d predictions pending",
                     quiet_cycles, predicted_parses.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin
        logic [7:0] base_sel;
        logic [7:0] fill_sel;
        logic [7:0] minus_sel;
        logic [7:0] plus_sel;

        cfg_base      = RST_NUMBER_BASE;
        cfg_fill      = RST_FILL_CHAR;
        cfg_minus     = RST_MINUS_CHAR;
        cfg_plus      = RST_PLUS_CHAR;
        cfg_fill_mode = RST_FILL_MODE;
        cfg_case      = RST_LETTER_CASE;
        prs_phase     = PH_LEAD;
        prs_mag       = '0;
        prs_neg       = 1'b0;
        prs_count     = '0;
        begin_pending = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults, digits after finish, disabled plus, byte extremes
        queue_text("-123x7");
        queue_text("+5");
        begin_pending = 1'b1;
        queue_char(8'hFF);
        begin_pending = 1'b1;
        queue_char(CHAR_NUL);

        // Radix 36, leading fill, letter bounds inclusive in both cases
        set_config(8'd36, " ", "-", "+", FILL_BEFORE_SIGN, CASE_BOTH);
        queue_text("  -zZaA9{");
        // Fill equal to the minus sign: fill wins before the sign
        set_config(8'd16, "-", "-", "+", FILL_BEFORE_SIGN, CASE_UPPER_ONLY);
        queue_text("--+Ff");
        // Radix below 2, fill after sign equal to a digit, lower case only
        set_config(8'd0, "0", "-", CHAR_NUL, FILL_AFTER_SIGN, CASE_LOWER_ONLY);
        queue_text("-0012");
        queue_text("-a");
        // Radix above 36, fill mode three, letter case three, minus disabled
        set_config(8'd63, CHAR_NUL, CHAR_NUL, CHAR_NUL, FILL_MODE_ALT, CASE_ALT);
        queue_text("-");
        queue_text("Zz");
        // Right fill: a leading fill character stops the parse
        set_config(8'd36, " ", "-", CHAR_NUL, FILL_RIGHT, CASE_BOTH);
        queue_text(" -12");
        queue_text("-1Z ");

        // Random phases, each split by a full drain of the results
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            if (k == 0) begin
                set_config(8'd36, 8'hFF, 8'hFF, "+", FILL_BEFORE_SIGN, CASE_BOTH);
            end else if (k == 1) begin
                set_config(8'd2, " ", "-", "+", FILL_AFTER_SIGN, CASE_UPPER_ONLY);
            end else begin
                case ($urandom_range(4, 0))
                    0: base_sel = 8'd2;
                    1: base_sel = 8'd36;
                    2: base_sel = 8'd10;
                    3: base_sel = 8'd16;
                    default: base_sel = 8'($urandom_range(63, 0));
                endcase
                case ($urandom_range(3, 0))
                    0: fill_sel = CHAR_NUL;
                    1: fill_sel = 8'hFF;
                    2: fill_sel = "0";
                    default: fill_sel = 8'($urandom_range(255, 0));
                endcase
                case ($urandom_range(3, 0))
                    0: minus_sel = "-";
                    1: minus_sel = CHAR_NUL;
                    default: minus_sel = 8'($urandom_range(255, 0));
                endcase
                case ($urandom_range(2, 0))
                    0: plus_sel = "+";
                    1: plus_sel = CHAR_NUL;
                    default: plus_sel = 8'($urandom_range(255, 0));
                endcase
                set_config(base_sel, fill_sel, minus_sel, plus_sel,
                           MODE_W'($urandom_range(3, 0)), MODE_W'($urandom_range(3, 0)));
            end

            case (t_idle'(k % 4))
                IDLE_NONE: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
                IDLE_SEND: begin sender_gap_pct = 64; receiver_stall_pct = 0;  end
                IDLE_RECV: begin sender_gap_pct = 0;  receiver_stall_pct = 64; end
                default:   begin sender_gap_pct = 6;  receiver_stall_pct = 6;  end
            endcase
            // receiver holds off while the sender keeps offering
            if (k == 0) stall_req = ~stall_req;

            repeat (2) begin
                while (text_chars.size() < HALF_PHASE) begin
                    if ($urandom_range(9, 0) == 0) begin
                        repeat ($urandom_range(4, 1)) begin
                            begin_pending = 1'($urandom_range(1, 0));
                            queue_char(CH_W'($urandom_range(255, 0)));
                        end
                    end else begin
                        queue_string();
                    end
                end
                wait_drained();
            end
        end

        repeat (8) @(posedge i_clk);
        if (predicted_parses.size() != 0)
            flag_error($sformatf("%0d predictions never answered", predicted_parses.size()));
        $display("Sent %0d characters, checked %0d results under %0d register settings,",
                 chars_sent, results_checked, configs_applied);
        $display("including idle/stall phases, a long receiver hold-off and wrapping values.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fttoi_pkg.sv
rtl/fttoi_decode.sv
rtl/fttoi_parse.sv
rtl/formatted_text_to_integer.sv
dv/tb_top.sv
